### src/qsm_pkg.sv
// Shared constants, types and arithmetic helpers for the misorientation block.
package qsm_pkg;

	localparam int MAX_SYM      = 64;
	localparam int COMP_WIDTH   = 16;
	localparam int FRAC_BITS    = COMP_WIDTH - 2;
	localparam int ADDR_W       = $clog2(MAX_SYM);
	localparam int CNT_W        = $clog2(MAX_SYM + 1);
	localparam int PROD_W       = COMP_WIDTH + 2;
	localparam int DOT_W        = COMP_WIDTH + 4;
	localparam int BEST_W       = DOT_W - 1;
	localparam int M_W          = FRAC_BITS + 1;
	localparam int SQ_W         = 2 * FRAC_BITS + 2;
	localparam int SQ_STEPS     = FRAC_BITS + 1;
	localparam int CORDIC_STEPS = 18;
	localparam int CORDIC_FRAC  = 30;
	localparam int CX_W         = CORDIC_FRAC + 4;
	localparam int CZ_W         = 24;
	localparam int ENTRY_W      = 4 * COMP_WIDTH;

	typedef logic signed [COMP_WIDTH-1:0] comp_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		logic            valid;
		logic [SQ_W-1:0] v;
		logic [SQ_W-1:0] r;
		logic [M_W-1:0]  m;
	} sq_beat_t;

	typedef struct packed {
		logic                   valid;
		logic signed [CX_W-1:0] x;
		logic signed [CX_W-1:0] y;
		logic signed [CZ_W-1:0] z;
	} cd_beat_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_WAIT = 3'b100
	} state_t;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic REG_SYM_COUNT = 1'b0;
	localparam logic REG_TOLERANCE = 1'b1;

	// Product of two components rounded half up to the component's fraction bits, two bits wider.
	function automatic prod_t mulr(input comp_t a, input comp_t b);
		logic signed [2*COMP_WIDTH-1:0] p;
		begin
			p = a * b + (2*COMP_WIDTH)'(1 << (FRAC_BITS - 1));
			return p[2*COMP_WIDTH-1:FRAC_BITS];
		end
	endfunction

	function automatic comp_t sat_comp(input logic signed [DOT_W-1:0] v);
		begin
			if (v > DOT_W'((1 << (COMP_WIDTH - 1)) - 1))
				return comp_t'((1 << (COMP_WIDTH - 1)) - 1);
			else if (v < -DOT_W'(1 << (COMP_WIDTH - 1)))
				return comp_t'(-(1 << (COMP_WIDTH - 1)));
			else
				return v[COMP_WIDTH-1:0];
		end
	endfunction

	function automatic logic [SQ_W-1:0] sqrt_bit(input logic [4:0] k);
		begin
			return SQ_W'(1) << (2 * FRAC_BITS - 2 * int'(k));
		end
	endfunction

	function automatic logic signed [CZ_W-1:0] atan_q20(input logic [4:0] k);
		begin
			case (k)
				5'd0:    return CZ_W'(823550);
				5'd1:    return CZ_W'(486170);
				5'd2:    return CZ_W'(256879);
				5'd3:    return CZ_W'(130396);
				5'd4:    return CZ_W'(65451);
				5'd5:    return CZ_W'(32757);
				5'd6:    return CZ_W'(16383);
				5'd7:    return CZ_W'(8192);
				5'd8:    return CZ_W'(4096);
				5'd9:    return CZ_W'(2048);
				5'd10:   return CZ_W'(1024);
				5'd11:   return CZ_W'(512);
				5'd12:   return CZ_W'(256);
				5'd13:   return CZ_W'(128);
				5'd14:   return CZ_W'(64);
				5'd15:   return CZ_W'(32);
				5'd16:   return CZ_W'(16);
				5'd17:   return CZ_W'(8);
				default: return '0;
			endcase
		end
	endfunction

endpackage

### src/qsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qsm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

### src/qsm_sqrt_cell.sv
// One restoring square-root cell: settles one result bit and passes the beat on.
module qsm_sqrt_cell import qsm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic [4:0] stage,
	input  sq_beat_t in,
	output sq_beat_t out
);
	logic [SQ_W-1:0] bit_v;
	logic [SQ_W-1:0] trial;
	logic            valid_q;
	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] r_q;
	logic [M_W-1:0]  m_q;

	assign bit_v = sqrt_bit(stage);
	assign trial = in.r + bit_v;
	assign out   = {valid_q, v_q, r_q, m_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= in.valid;
	end

	always_ff @(posedge clk) begin
		m_q <= in.m;
		if (in.v >= trial) begin
			v_q <= in.v - trial;
			r_q <= (in.r >> 1) + bit_v;
		end else begin
			v_q <= in.v;
			r_q <= in.r >> 1;
		end
	end
endmodule

### src/qsm_cordic_cell.sv
// One vectoring CORDIC cell: rotates toward the x axis and accumulates the angle.
module qsm_cordic_cell import qsm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic [4:0] stage,
	input  cd_beat_t in,
	output cd_beat_t out
);
	logic signed [CX_W-1:0] dx;
	logic signed [CX_W-1:0] dy;
	logic                   valid_q;
	logic signed [CX_W-1:0] x_q;
	logic signed [CX_W-1:0] y_q;
	logic signed [CZ_W-1:0] z_q;

	assign dx  = in.y >>> stage;
	assign dy  = in.x >>> stage;
	assign out = {valid_q, x_q, y_q, z_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= in.valid;
	end

	always_ff @(posedge clk) begin
		if (!in.y[CX_W-1]) begin
			x_q <= in.x + dx;
			y_q <= in.y - dy;
			z_q <= in.z + atan_q20(stage);
		end else begin
			x_q <= in.x - dx;
			y_q <= in.y + dy;
			z_q <= in.z - atan_q20(stage);
		end
	end
endmodule

### src/quaternion_symmetry_misorientation.sv
// Top level: symmetry table, product scan with running maximum, sqrt and CORDIC cell rows.
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------------
//  command  | start / busy      | op, sym_index, a_w..a_z, b_w..b_z
//  result   | done (one cycle)  | angle, status
//  config   | cfg_we            | cfg_index, cfg_data
//
// A load beat writes one table entry and leaves busy low. A query reads
// one entry per cycle through the table read port for n >= 1 table entries
// used, through the read, product, dot and maximum registers (skipped for
// n = 0), then through 15 square root cells and 18 CORDIC cells in a row.
// busy stays high until the cycle of done; the result side never stalls.
// Reset clears control state only; the table is not cleared.
module quaternion_symmetry_misorientation import qsm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [7:0]             cfg_data,
	input  logic                   op,
	input  logic [5:0]             sym_index,
	input  logic signed [15:0]     a_w,
	input  logic signed [15:0]     a_x,
	input  logic signed [15:0]     a_y,
	input  logic signed [15:0]     a_z,
	input  logic signed [15:0]     b_w,
	input  logic signed [15:0]     b_x,
	input  logic signed [15:0]     b_y,
	input  logic signed [15:0]     b_z,
	output logic                   done,
	output logic [15:0]            angle,
	output logic                   status
);
	localparam logic [BEST_W-1:0] ONE = BEST_W'(1 << FRAC_BITS);

	state_t             state_q;
	logic [6:0]         count_q;
	logic [7:0]         tol_q;
	logic [CNT_W-1:0]   n;
	logic [CNT_W-1:0]   idx_q;
	comp_t              qa_q [4];
	comp_t              qb_q [4];
	logic               accept;
	logic               issue;
	logic               issue_last;
	logic               rv_s1, rl_s1;
	logic               pv_s2, pl_s2;
	logic               dv_s3, dl_s3;
	logic               fin_q;
	logic [ENTRY_W-1:0] rdata;
	comp_t              s [4];
	comp_t              p_s2 [4];
	logic [BEST_W-1:0]  d_s3;
	logic [BEST_W-1:0]  best_q;
	logic               zero_q;
	logic               over_q;
	logic signed [DOT_W-1:0] pw, px, py, pz, dot;
	logic signed [CZ_W-1:0]  zr;
	sq_beat_t           sq [SQ_STEPS+1];
	cd_beat_t           cd [CORDIC_STEPS+1];

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign n      = (count_q > 7'(MAX_SYM)) ? CNT_W'(MAX_SYM) : CNT_W'(count_q);
	assign issue  = (state_q == S_SCAN);
	assign issue_last = issue && (idx_q + CNT_W'(1) == n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 7'd1;
			tol_q   <= 8'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYM_COUNT: count_q <= cfg_data[6:0];
				REG_TOLERANCE: tol_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	qsm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SYM)) u_table (
		.clk   (clk),
		.we    (accept && (op == OP_LOAD)),
		.waddr (sym_index[ADDR_W-1:0]),
		.wdata ({a_w, a_x, a_y, a_z}),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			rv_s1   <= 1'b0;
			pv_s2   <= 1'b0;
			dv_s3   <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			rv_s1 <= issue;
			pv_s2 <= rv_s1;
			dv_s3 <= pv_s2;
			fin_q <= (dv_s3 && dl_s3) || (accept && op == OP_QUERY && n == '0);
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (accept && op == OP_QUERY)
						state_q <= (n == '0) ? S_WAIT : S_SCAN;
				end
				S_SCAN: begin
					idx_q <= idx_q + CNT_W'(1);
					if (issue_last)
						state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (cd[CORDIC_STEPS].valid)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s[0] = rdata[63:48];
	assign s[1] = rdata[47:32];
	assign s[2] = rdata[31:16];
	assign s[3] = rdata[15:0];

	// Hamilton product P = B * S, each term rounded before the sum.
	always_comb begin
		pw = DOT_W'(mulr(qb_q[0], s[0])) - DOT_W'(mulr(qb_q[1], s[1]))
		   - DOT_W'(mulr(qb_q[2], s[2])) - DOT_W'(mulr(qb_q[3], s[3]));
		px = DOT_W'(mulr(qb_q[1], s[0])) + DOT_W'(mulr(qb_q[0], s[1]))
		   - DOT_W'(mulr(qb_q[3], s[2])) + DOT_W'(mulr(qb_q[2], s[3]));
		py = DOT_W'(mulr(qb_q[2], s[0])) + DOT_W'(mulr(qb_q[3], s[1]))
		   + DOT_W'(mulr(qb_q[0], s[2])) - DOT_W'(mulr(qb_q[1], s[3]));
		pz = DOT_W'(mulr(qb_q[3], s[0])) - DOT_W'(mulr(qb_q[2], s[1]))
		   + DOT_W'(mulr(qb_q[1], s[2])) + DOT_W'(mulr(qb_q[0], s[3]));
		dot = DOT_W'(mulr(qa_q[0], p_s2[0])) + DOT_W'(mulr(qa_q[1], p_s2[1]))
		    + DOT_W'(mulr(qa_q[2], p_s2[2])) + DOT_W'(mulr(qa_q[3], p_s2[3]));
	end

	always_ff @(posedge clk) begin
		if (accept && op == OP_QUERY) begin
			qa_q[0] <= a_w; qa_q[1] <= a_x; qa_q[2] <= a_y; qa_q[3] <= a_z;
			qb_q[0] <= b_w; qb_q[1] <= b_x; qb_q[2] <= b_y; qb_q[3] <= b_z;
		end
		rl_s1   <= issue_last;
		p_s2[0] <= sat_comp(pw);
		p_s2[1] <= sat_comp(px);
		p_s2[2] <= sat_comp(py);
		p_s2[3] <= sat_comp(pz);
		pl_s2   <= rl_s1;
		d_s3    <= dot[DOT_W-1] ? BEST_W'(-dot) : BEST_W'(dot);
		dl_s3   <= pl_s2;
		if (accept && op == OP_QUERY)
			best_q <= '0;
		else if (dv_s3 && d_s3 > best_q)
			best_q <= d_s3;
		if (fin_q) begin
			zero_q <= (best_q > ONE);
			over_q <= (best_q > ONE) && (best_q - ONE > BEST_W'(tol_q));
		end
	end

	// The square root row gets 1 - m*m; beyond one the row still runs, its angle unused.
	always_comb begin
		sq[0].valid = fin_q;
		sq[0].m     = (best_q > ONE) ? '0 : best_q[M_W-1:0];
		sq[0].v     = SQ_W'(ONE) * SQ_W'(ONE) - SQ_W'(sq[0].m) * SQ_W'(sq[0].m);
		sq[0].r     = '0;
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		qsm_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.stage  (5'(k)),
			.in     (sq[k]),
			.out    (sq[k+1])
		);
	end

	always_comb begin
		cd[0].valid = sq[SQ_STEPS].valid;
		cd[0].x     = CX_W'(sq[SQ_STEPS].m) <<< (CORDIC_FRAC - FRAC_BITS);
		cd[0].y     = CX_W'(sq[SQ_STEPS].r) <<< (CORDIC_FRAC - FRAC_BITS);
		cd[0].z     = '0;
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cd
		qsm_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.stage  (5'(k)),
			.in     (cd[k]),
			.out    (cd[k+1])
		);
	end

	assign zr = (cd[CORDIC_STEPS].z + CZ_W'(32)) >>> 6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= cd[CORDIC_STEPS].valid;
	end

	always_ff @(posedge clk) begin
		if (cd[CORDIC_STEPS].valid) begin
			status <= over_q;
			if (zero_q || zr[CZ_W-1])
				angle <= '0;
			else if (zr > CZ_W'(65535))
				angle <= 16'hFFFF;
			else
				angle <= zr[15:0];
		end
	end
endmodule
